/* src/bfci_pkg.sv */
// Package: shared types, codes and constants of the banked flash command interface.
package bfci_pkg;

    localparam int BANK_BYTES        = 16384;
    localparam int ERASE_BLOCK_BYTES = 65536;
    localparam int FLASH_BLOCKS      = 8;

    localparam int OFFSET_W = $clog2(BANK_BYTES);
    localparam int BLOCK_W  = $clog2(ERASE_BLOCK_BYTES);
    localparam int PAGE_W   = 5;
    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int OP_W     = 3;
    localparam int MADDR_W  = 19;
    localparam int BLKNUM_W = MADDR_W - BLOCK_W;

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_MEM_READ   = 3'd0,
        CMD_MEM_WRITE  = 3'd1,
        CMD_PAGE_WRITE = 3'd2,
        CMD_PAGE_READ  = 3'd3,
        CMD_PORT_WRITE = 3'd4,
        CMD_CARD_WRITE = 3'd5
    } cmd_t;

    // Memory operation codes
    typedef enum logic [OP_W-1:0] {
        OP_NONE        = 3'd0,
        OP_RD_FLASH    = 3'd1,
        OP_RD_RAM      = 3'd2,
        OP_PROGRAM     = 3'd3,
        OP_WR_RAM      = 3'd4,
        OP_ERASE_BLOCK = 3'd5,
        OP_ERASE_CHIP  = 3'd6
    } mem_op_t;

    localparam logic [7:0] PAGING_RESET = 8'h60;
    localparam logic [3:0] CARD_UNLOCK  = 4'hA;
    localparam logic [7:0] STATUS_BYTE  = 8'hFF;

    // One result item
    typedef struct packed {
        mem_op_t                mem_op;
        logic [MADDR_W-1:0]     mem_address;
        logic [DATA_W-1:0]      write_data;
        logic                   claimed;
        logic                   reply_valid;
        logic [DATA_W-1:0]      reply_data;
        logic                   last;
    } item_t;

    // Results of one accepted input: one or two items
    typedef struct packed {
        logic  two;
        item_t first;
        item_t second;
    } pair_t;

endpackage

/* src/bfci_if.sv */
// Interfaces: request, result and configuration channels.
interface bfci_req_if;
    import bfci_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    modport source (output valid, command, address, data, input ready);
    modport sink   (input valid, command, address, data, output ready);
endinterface

interface bfci_rsp_if;
    import bfci_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    mem_op;
    logic [MADDR_W-1:0] mem_address;
    logic [DATA_W-1:0]  write_data;
    logic               claimed;
    logic               reply_valid;
    logic [DATA_W-1:0]  reply_data;
    logic               last;
    modport source (output valid, mem_op, mem_address, write_data, claimed,
                    reply_valid, reply_data, last, input ready);
    modport sink   (input valid, mem_op, mem_address, write_data, claimed,
                    reply_valid, reply_data, last, output ready);
endinterface

interface bfci_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/bfci_core.sv */
// Core: paging state, flash command sequencer and result item decode.
module bfci_core (
    input  logic            clk,
    input  logic            rst_n,
    bfci_req_if.sink        req,
    bfci_cfg_if.sink        cfg,
    input  logic            space,
    output bfci_pkg::pair_t pair
);
    import bfci_pkg::*;

    typedef enum logic [2:0] {
        STEP_ONE   = 3'd1,
        STEP_TWO   = 3'd2,
        STEP_THREE = 3'd3,
        STEP_FOUR  = 3'd4,
        STEP_FIVE  = 3'd5,
        STEP_SIX   = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        PFX_NONE         = 3'd0,
        PFX_BYPASS_PROG  = 3'd1,
        PFX_BYPASS_RESET = 3'd2,
        PFX_LONG_ONE     = 3'd3,
        PFX_PROGRAM      = 3'd4,
        PFX_LONG_TWO     = 3'd5
    } prefix_t;

    logic       protect_reg;
    logic [7:0] paging_reg,  paging_next;
    logic [3:0] card_reg,    card_next;
    step_t      step_reg,    step_next;
    prefix_t    prefix_reg,  prefix_next;
    logic       status_reg,  status_next;

    logic                 accept;
    logic                 in_win;
    logic [MADDR_W-1:0]   phys;
    logic [10:0]          ccode;
    logic [BLKNUM_W-1:0]  blk;
    logic                 flash_en;
    mem_op_t              fop;
    logic [MADDR_W-1:0]   faddr;
    item_t                blank;

    assign accept    = req.valid && req.ready;
    assign req.ready = space;
    assign cfg.ready = 1'b1;

    assign in_win   = (req.address[ADDR_W-1:OFFSET_W] == '0);
    assign phys     = {paging_reg[PAGE_W-1:0], req.address[OFFSET_W-1:0]};
    assign ccode    = req.address[10:0];
    assign blk      = phys[MADDR_W-1:BLOCK_W];
    assign flash_en = (req.command == CMD_MEM_WRITE) && in_win && paging_reg[5]
                      && (card_reg == CARD_UNLOCK);

    always_comb
    begin
        blank = '{mem_op: OP_NONE, mem_address: '0, write_data: '0, claimed: 1'b0,
                  reply_valid: 1'b0, reply_data: '0, last: 1'b1};
    end

    // Command sequencer
    always_comb
    begin
        step_next   = step_reg;
        prefix_next = prefix_reg;
        status_next = status_reg;
        fop         = OP_NONE;
        faddr       = '0;
        if (flash_en)
        begin
            step_next = STEP_ONE;
            unique case (step_reg)
                STEP_ONE:
                begin
                    if (ccode == 11'h555 && req.data == 8'hAA)
                    begin
                        prefix_next = PFX_LONG_ONE;
                        step_next   = STEP_TWO;
                    end
                    else if (req.data == 8'hA0)
                    begin
                        prefix_next = PFX_BYPASS_PROG;
                        step_next   = STEP_TWO;
                    end
                    else if (req.data == 8'h90)
                    begin
                        prefix_next = PFX_BYPASS_RESET;
                        step_next   = STEP_TWO;
                    end
                    else if (req.data == 8'hF0)
                        status_next = 1'b0;
                end
                STEP_TWO:
                begin
                    if (prefix_reg != PFX_BYPASS_PROG && prefix_reg != PFX_BYPASS_RESET
                        && ccode == 11'h2AA && req.data == 8'h55)
                        step_next = STEP_THREE;
                end
                STEP_THREE:
                begin
                    if (req.data == 8'hF0)
                        status_next = 1'b0;
                    else if (ccode == 11'h555)
                    begin
                        if (req.data == 8'hA0)
                        begin
                            prefix_next = PFX_PROGRAM;
                            step_next   = STEP_FOUR;
                        end
                        else if (req.data == 8'h80)
                        begin
                            prefix_next = PFX_LONG_TWO;
                            step_next   = STEP_FOUR;
                        end
                    end
                end
                STEP_FOUR:
                begin
                    if (prefix_reg == PFX_PROGRAM)
                    begin
                        fop   = OP_PROGRAM;
                        faddr = phys;
                    end
                    else if (ccode == 11'h555 && req.data == 8'hAA)
                        step_next = STEP_FIVE;
                end
                STEP_FIVE:
                begin
                    if (ccode == 11'h2AA && req.data == 8'h55)
                        step_next = STEP_SIX;
                end
                STEP_SIX:
                begin
                    if (ccode == 11'h555 && req.data == 8'h10)
                    begin
                        fop         = OP_ERASE_CHIP;
                        status_next = 1'b1;
                    end
                    else if (req.data == 8'h30)
                    begin
                        status_next = 1'b1;
                        if (32'(blk) < FLASH_BLOCKS)
                        begin
                            fop   = OP_ERASE_BLOCK;
                            faddr = {blk, {BLOCK_W{1'b0}}};
                        end
                    end
                end
                default: ;
            endcase
            if (protect_reg)
                fop = OP_NONE;
        end
        // read side of the status byte
        if (req.command == CMD_MEM_READ && in_win && paging_reg[6] && paging_reg[5])
            status_next = 1'b0;
    end

    // Result decode and paging updates
    always_comb
    begin
        paging_next = paging_reg;
        card_next   = card_reg;
        pair.two    = 1'b0;
        pair.first  = blank;
        pair.second = blank;
        case (req.command)
            CMD_MEM_READ:
            begin
                if (in_win && paging_reg[6])
                begin
                    pair.first.claimed = 1'b1;
                    if (!paging_reg[5])
                    begin
                        pair.first.mem_op      = OP_RD_RAM;
                        pair.first.mem_address = phys;
                    end
                    else if (status_reg)
                    begin
                        pair.first.reply_valid = 1'b1;
                        pair.first.reply_data  = STATUS_BYTE;
                    end
                    else
                    begin
                        pair.first.mem_op      = OP_RD_FLASH;
                        pair.first.mem_address = phys;
                    end
                end
            end
            CMD_MEM_WRITE:
            begin
                if (in_win)
                begin
                    if (fop != OP_NONE)
                    begin
                        pair.first.mem_op      = fop;
                        pair.first.mem_address = faddr;
                        pair.first.write_data  = (fop == OP_PROGRAM) ? req.data : STATUS_BYTE;
                        pair.first.last        = !paging_reg[7];
                        if (paging_reg[7])
                        begin
                            pair.two                = 1'b1;
                            pair.second.mem_op      = OP_WR_RAM;
                            pair.second.mem_address = phys;
                            pair.second.write_data  = req.data;
                        end
                    end
                    else if (paging_reg[7])
                    begin
                        pair.first.mem_op      = OP_WR_RAM;
                        pair.first.mem_address = phys;
                        pair.first.write_data  = req.data;
                    end
                end
            end
            CMD_PAGE_WRITE: paging_next = req.data;
            CMD_PAGE_READ:
            begin
                pair.first.claimed     = 1'b1;
                pair.first.reply_valid = 1'b1;
                pair.first.reply_data  = paging_reg;
            end
            CMD_PORT_WRITE:
            begin
                if (paging_reg[6:5] != 2'b10)
                    paging_next[0] = req.data[4];
            end
            CMD_CARD_WRITE: card_next = req.data[7:4];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protect_reg <= 1'b0;
            paging_reg  <= PAGING_RESET;
            card_reg    <= '0;
            step_reg    <= STEP_ONE;
            prefix_reg  <= PFX_NONE;
            status_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                protect_reg <= cfg.data;
            if (accept)
            begin
                paging_reg <= paging_next;
                card_reg   <= card_next;
                step_reg   <= step_next;
                prefix_reg <= prefix_next;
                status_reg <= status_next;
            end
        end
    end

endmodule

/* src/bfci_outbuf.sv */
// Output buffer: two item slots that feed the result channel in order.
module bfci_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bfci_pkg::pair_t pair,
    output logic            space,
    bfci_rsp_if.source      rsp
);
    import bfci_pkg::*;

    logic [1:0] count_reg, count_next;
    item_t      slot0_reg, slot0_next;
    item_t      slot1_reg, slot1_next;
    logic       pop;

    assign pop   = rsp.valid && rsp.ready;
    assign space = (count_reg == 2'd0) || (count_reg == 2'd1 && rsp.ready);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push)
        begin
            slot0_next = pair.first;
            slot1_next = pair.second;
            count_next = pair.two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign rsp.valid       = (count_reg != 2'd0);
    assign rsp.mem_op      = slot0_reg.mem_op;
    assign rsp.mem_address = slot0_reg.mem_address;
    assign rsp.write_data  = slot0_reg.write_data;
    assign rsp.claimed     = slot0_reg.claimed;
    assign rsp.reply_valid = slot0_reg.reply_valid;
    assign rsp.reply_data  = slot0_reg.reply_data;
    assign rsp.last        = slot0_reg.last;

endmodule

/* src/banked_flash_command_interface_top.sv */
// Top level: banked memory pager with flash command sequencer.
//
// Channels:
//   req - one item per CPU bus event: command, address, data.
//   rsp - result items; each request gives one or two, the final one
//         flagged by last. A RAM write that follows a flash program or
//         erase in the same access comes as a second item.
//   cfg - write of the flash write protect bit, always ready; write it
//         only while no request is in flight.
// Results are registered: an item shows in the cycle after its request is taken.
// Throughput: one request per cycle while rsp is ready; a request with two
//   result items holds req off until the single output port has drained the
//   first item from the two-slot output buffer.
// Reset: paging register 0x60 (flash paged in for reads), card select
//   nibble zero, sequencer at its first step, no status pending, write
//   protect off, output buffer empty.
// Stall: when rsp is not ready, held items stay on the port and req.ready
//   drops once the buffer cannot take a new request's results.
module banked_flash_command_interface_top (
    input  logic       clk,
    input  logic       rst_n,
    bfci_req_if.sink   req,
    bfci_rsp_if.source rsp,
    bfci_cfg_if.sink   cfg
);
    import bfci_pkg::*;

    pair_t pair;
    logic  space;
    logic  push;

    // state updates and decode happen at the request handshake
    assign push = req.valid && space;

    bfci_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .space (space),
        .pair  (pair)
    );

    // result register stage between the two sides
    bfci_outbuf u_outbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pair  (pair),
        .space (space),
        .rsp   (rsp)
    );

endmodule

/* bench/testbench.sv */
// Testbench: directed table and random JEDEC traffic checked item by item against a pager model.
module testbench;
    import bfci_pkg::*;

    // Run limits
    localparam int unsigned LIMIT_CYCLES    = 400000;
    localparam int          ITEMS_PER_PHASE = 275;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          N_DIRECTED      = 26;

    // Command cycle addresses (low 11 bits of the physical address) and bytes
    localparam logic [10:0] UNLOCK_ADDR1 = 11'h555;
    localparam logic [10:0] UNLOCK_ADDR2 = 11'h2AA;
    localparam logic [7:0]  CB_UNLOCK1   = 8'hAA;
    localparam logic [7:0]  CB_UNLOCK2   = 8'h55;
    localparam logic [7:0]  CB_PROGRAM   = 8'hA0;
    localparam logic [7:0]  CB_AUTOSEL   = 8'h90;
    localparam logic [7:0]  CB_ERASE     = 8'h80;
    localparam logic [7:0]  CB_CHIP      = 8'h10;
    localparam logic [7:0]  CB_BLOCK     = 8'h30;
    localparam logic [7:0]  CB_RESET     = 8'hF0;

    // Codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // What the sequencer remembers of the cycles seen so far
    typedef enum logic [2:0] {
        PX_NONE, PX_BYPASS_PROG, PX_BYPASS_RESET, PX_UNLOCKED, PX_PROGRAM, PX_ERASE
    } seq_prefix_t;

    // Shapes of well-formed command sequences for the random part
    typedef enum int {JK_PROGRAM, JK_CHIP_ERASE, JK_BLOCK_ERASE, JK_RESET3} jedec_kind_t;

    // One bus item as offered; typed rows carry their expected result
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        bit                typed;
        item_t             want;
    } bus_item_t;

    logic clk;
    logic rst_n;

    bfci_req_if req_ch();
    bfci_rsp_if rsp_ch();
    bfci_cfg_if cfg_ch();

    banked_flash_command_interface_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the pager and sequencer state
    logic        wprot;
    logic [7:0]  pg_ctl;
    logic [3:0]  card_nib;
    logic [2:0]  seq_step;
    seq_prefix_t seq_pfx;
    logic        status_pend;

    item_t       pending_results[$];
    bus_item_t   stim_q[$];
    bus_item_t   on_bus;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    // Idle controls; the last phase runs with both off
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_gap    = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One write cycle into the JEDEC sequencer. Every cycle drops back to
    // the first step unless it matches what the current step waits for.
    task automatic advance_sequence(input logic [MADDR_W-1:0] phys, input logic [7:0] v,
                                    output mem_op_t op, output logic [MADDR_W-1:0] op_addr);
        logic [10:0]         low;
        logic [2:0]          cur;
        logic [BLKNUM_W-1:0] blk;
        low = phys[10:0];
        cur = seq_step;
        blk = phys[MADDR_W-1:BLOCK_W];
        op = OP_NONE;
        op_addr = '0;
        seq_step = 3'd1;
        case (cur)
            3'd1:
            begin
                if (low == UNLOCK_ADDR1 && v == CB_UNLOCK1)
                begin
                    seq_pfx = PX_UNLOCKED;
                    seq_step = 3'd2;
                end
                else if (v == CB_PROGRAM)
                begin
                    seq_pfx = PX_BYPASS_PROG;
                    seq_step = 3'd2;
                end
                else if (v == CB_AUTOSEL)
                begin
                    seq_pfx = PX_BYPASS_RESET;
                    seq_step = 3'd2;
                end
                else if (v == CB_RESET)
                    status_pend = 1'b0;
            end
            3'd2:
            begin
                // bypass prefixes are not implemented: they only burn a step
                if (seq_pfx != PX_BYPASS_PROG && seq_pfx != PX_BYPASS_RESET
                    && low == UNLOCK_ADDR2 && v == CB_UNLOCK2)
                    seq_step = 3'd3;
            end
            3'd3:
            begin
                if (v == CB_RESET)
                    status_pend = 1'b0;
                else if (low == UNLOCK_ADDR1)
                begin
                    if (v == CB_PROGRAM)
                    begin
                        seq_pfx = PX_PROGRAM;
                        seq_step = 3'd4;
                    end
                    else if (v == CB_ERASE)
                    begin
                        seq_pfx = PX_ERASE;
                        seq_step = 3'd4;
                    end
                end
            end
            3'd4:
            begin
                if (seq_pfx == PX_PROGRAM)
                begin
                    op = OP_PROGRAM;
                    op_addr = phys;
                end
                else if (low == UNLOCK_ADDR1 && v == CB_UNLOCK1)
                    seq_step = 3'd5;
            end
            3'd5:
            begin
                if (low == UNLOCK_ADDR2 && v == CB_UNLOCK2)
                    seq_step = 3'd6;
            end
            3'd6:
            begin
                if (low == UNLOCK_ADDR1 && v == CB_CHIP)
                begin
                    op = OP_ERASE_CHIP;
                    status_pend = 1'b1;
                end
                else if (v == CB_BLOCK)
                begin
                    // status goes pending even for a block past the chip
                    status_pend = 1'b1;
                    if (int'(blk) < FLASH_BLOCKS)
                    begin
                        op = OP_ERASE_BLOCK;
                        op_addr = MADDR_W'(blk) << BLOCK_W;
                    end
                end
            end
            default: ;
        endcase
        // protect only hides the operation; sequence and status move anyway
        if (wprot)
            op = OP_NONE;
    endtask

    // Results of one accepted bus item, updating the shadow state.
    task automatic pager_outcome(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data, output pair_t res);
        logic [MADDR_W-1:0] phys;
        logic [MADDR_W-1:0] faddr;
        mem_op_t            fop;
        item_t              slot[2];
        int                 n;
        slot[0] = '0;
        slot[1] = '0;
        n = 0;
        phys = {pg_ctl[4:0], {OFFSET_W{1'b0}}} + MADDR_W'(addr);
        case (cmd)
            CMD_MEM_READ:
            begin
                if (addr < BANK_BYTES && pg_ctl[6])
                begin
                    slot[0].claimed = 1'b1;
                    if (!pg_ctl[5])
                    begin
                        // RAM read leaves a pending status alone
                        slot[0].mem_op = OP_RD_RAM;
                        slot[0].mem_address = phys;
                    end
                    else if (status_pend)
                    begin
                        status_pend = 1'b0;
                        slot[0].reply_valid = 1'b1;
                        slot[0].reply_data = STATUS_BYTE;
                    end
                    else
                    begin
                        slot[0].mem_op = OP_RD_FLASH;
                        slot[0].mem_address = phys;
                    end
                end
            end
            CMD_MEM_WRITE:
            begin
                if (addr < BANK_BYTES)
                begin
                    if (pg_ctl[5] && card_nib == CARD_UNLOCK)
                    begin
                        advance_sequence(phys, data, fop, faddr);
                        if (fop != OP_NONE)
                        begin
                            slot[n].mem_op = fop;
                            slot[n].mem_address = faddr;
                            slot[n].write_data = (fop == OP_PROGRAM) ? data : 8'hFF;
                            n++;
                        end
                    end
                    // RAM write follows the flash item in the same access
                    if (pg_ctl[7])
                    begin
                        slot[n].mem_op = OP_WR_RAM;
                        slot[n].mem_address = phys;
                        slot[n].write_data = data;
                        n++;
                    end
                end
            end
            CMD_PAGE_WRITE:
                pg_ctl = data;
            CMD_PAGE_READ:
            begin
                slot[0].claimed = 1'b1;
                slot[0].reply_valid = 1'b1;
                slot[0].reply_data = pg_ctl;
            end
            CMD_PORT_WRITE:
            begin
                // no copy while RAM is paged in for reads
                if (pg_ctl[6:5] != 2'b10)
                    pg_ctl[0] = data[4];
            end
            CMD_CARD_WRITE:
                card_nib = data[7:4];
            default: ;
        endcase
        if (n == 0)
            n = 1;
        slot[n-1].last = 1'b1;
        res.two = (n == 2);
        res.first = slot[0];
        res.second = slot[1];
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_result(input item_t want);
        if (rsp_ch.mem_op !== want.mem_op)
        begin
            $error("mem_op: expected %0d, actual %0d", want.mem_op, rsp_ch.mem_op);
            fail_count++;
        end
        if (rsp_ch.mem_address !== want.mem_address)
        begin
            $error("mem_address: expected %h, actual %h", want.mem_address, rsp_ch.mem_address);
            fail_count++;
        end
        if (rsp_ch.write_data !== want.write_data)
        begin
            $error("write_data: expected %h, actual %h", want.write_data, rsp_ch.write_data);
            fail_count++;
        end
        if (rsp_ch.claimed !== want.claimed)
        begin
            $error("claimed: expected %b, actual %b", want.claimed, rsp_ch.claimed);
            fail_count++;
        end
        if (rsp_ch.reply_valid !== want.reply_valid)
        begin
            $error("reply_valid: expected %b, actual %b", want.reply_valid, rsp_ch.reply_valid);
            fail_count++;
        end
        if (rsp_ch.reply_data !== want.reply_data)
        begin
            $error("reply_data: expected %h, actual %h", want.reply_data, rsp_ch.reply_data);
            fail_count++;
        end
        if (rsp_ch.last !== want.last)
        begin
            $error("last: expected %b, actual %b", want.last, rsp_ch.last);
            fail_count++;
        end
    endtask

    // All sampling happens here, at the rising edge. Inputs only move at the
    // falling edge, so nothing depends on event order inside a time step.
    always @(posedge clk)
    begin : monitor
        pair_t pr;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready === 1'b1)
                wprot = cfg_ch.data;
            if (req_ch.valid && req_ch.ready === 1'b1)
            begin
                // shadow state moves on for typed rows too
                pager_outcome(req_ch.command, req_ch.address, req_ch.data, pr);
                if (on_bus.typed)
                    pending_results.push_back(on_bus.want);
                else
                begin
                    pending_results.push_back(pr.first);
                    if (pr.two)
                        pending_results.push_back(pr.second);
                end
            end
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    fail_count++;
                end
                else
                    check_result(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL banked_flash_command_interface_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic item_t known_item(input mem_op_t op, input logic [MADDR_W-1:0] a,
                                         input logic [7:0] wd, input logic cl,
                                         input logic rv, input logic [7:0] rd);
        item_t it;
        it.mem_op = op;
        it.mem_address = a;
        it.write_data = wd;
        it.claimed = cl;
        it.reply_valid = rv;
        it.reply_data = rd;
        it.last = 1'b1;
        return it;
    endfunction

    function automatic bus_item_t row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data, input bit typed,
                                      input item_t want);
        bus_item_t r;
        r.cmd = cmd;
        r.addr = addr;
        r.data = data;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    // Directed table. Rows with a typed result are plain enough to read off
    // directly; the rest go through the shadow model.
    function automatic bus_item_t directed_row(input int i);
        item_t nil;
        item_t pred;
        bus_item_t r;
        nil = known_item(OP_NONE, '0, 8'h00, 1'b0, 1'b0, 8'h00);
        pred = '0;
        case (i)
            // state straight out of reset
            0:  r = row(CMD_PAGE_READ, 16'h0000, 8'h00, 1'b1,
                        known_item(OP_NONE, '0, 8'h00, 1'b1, 1'b1, PAGING_RESET));
            1:  r = row(CMD_MEM_READ, 16'h0000, 8'h00, 1'b1,
                        known_item(OP_RD_FLASH, '0, 8'h00, 1'b1, 1'b0, 8'h00));
            // outside the window: not claimed
            2:  r = row(CMD_MEM_READ, 16'hFFFF, 8'hFF, 1'b1, nil);
            3:  r = row(CMD_CARD_WRITE, 16'h0000, 8'hA0, 1'b1, nil);
            // all paging bits set, top page
            4:  r = row(CMD_PAGE_WRITE, 16'hFFFF, 8'hFF, 1'b1, nil);
            5:  r = row(CMD_PAGE_READ, 16'h0000, 8'h00, 1'b1,
                        known_item(OP_NONE, '0, 8'h00, 1'b1, 1'b1, 8'hFF));
            // last byte of the last page
            6:  r = row(CMD_MEM_WRITE, 16'h3FFF, 8'h00, 1'b0, pred);
            // 128K port bit copied into the page
            7:  r = row(CMD_PORT_WRITE, 16'h0000, 8'hEF, 1'b0, pred);
            8:  r = row(CMD_PAGE_WRITE, 16'h0000, 8'hE7, 1'b1, nil);
            // chip erase with RAM write enable: two items on the last cycle
            9:  r = row(CMD_MEM_WRITE, 16'h0555, CB_UNLOCK1, 1'b0, pred);
            10: r = row(CMD_MEM_WRITE, 16'h02AA, CB_UNLOCK2, 1'b0, pred);
            11: r = row(CMD_MEM_WRITE, 16'h0555, CB_ERASE, 1'b0, pred);
            12: r = row(CMD_MEM_WRITE, 16'h0555, CB_UNLOCK1, 1'b0, pred);
            13: r = row(CMD_MEM_WRITE, 16'h02AA, CB_UNLOCK2, 1'b0, pred);
            14: r = row(CMD_MEM_WRITE, 16'h0555, CB_CHIP, 1'b0, pred);
            // status byte once, then a real flash read
            15: r = row(CMD_MEM_READ, 16'h0ABC, 8'h00, 1'b0, pred);
            16: r = row(CMD_MEM_READ, 16'h0ABC, 8'h00, 1'b0, pred);
            // read/reset in the first step
            17: r = row(CMD_MEM_WRITE, 16'h0555, CB_RESET, 1'b0, pred);
            18: r = row(CMD_CARD_WRITE, 16'h0000, 8'h00, 1'b1, nil);
            // RAM paged in for reads: port write must not touch the page
            19: r = row(CMD_PAGE_WRITE, 16'h0000, 8'h40, 1'b1, nil);
            20: r = row(CMD_PORT_WRITE, 16'h0000, 8'h10, 1'b0, pred);
            21: r = row(CMD_MEM_READ, 16'h2000, 8'h00, 1'b0, pred);
            // page-in off: read not claimed
            22: r = row(CMD_PAGE_WRITE, 16'h0000, 8'h00, 1'b1, nil);
            23: r = row(CMD_MEM_READ, 16'h0000, 8'h00, 1'b1, nil);
            // unused command codes
            24: r = row(CMD_UNUSED_6, 16'h1234, 8'h5A, 1'b1, nil);
            default: r = row(CMD_UNUSED_7, 16'hA5A5, 8'hA5, 1'b1, nil);
        endcase
        return r;
    endfunction

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data);
        stim_q.push_back(row(cmd, addr, data, 1'b0, '0));
    endtask

    function automatic logic [ADDR_W-1:0] rand_window();
        return ADDR_W'($urandom_range(0, BANK_BYTES - 1));
    endfunction

    // Mostly flash selected and paged in, so sequences get through
    task automatic offer_paging();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 9) < 8)
            v[6:5] = 2'b11;
        offer(CMD_PAGE_WRITE, 16'($urandom), v);
    endtask

    task automatic offer_card();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 9) < 8)
            v[7:4] = CARD_UNLOCK;
        offer(CMD_CARD_WRITE, 16'($urandom), v);
    endtask

    // A full command sequence with random content; now and then one cycle
    // is spoiled so the sequencer has to fall back.
    task automatic offer_jedec(input jedec_kind_t kind);
        logic [10:0] lows[$];
        logic [7:0]  vals[$];
        int          j;
        lows.push_back(UNLOCK_ADDR1);
        vals.push_back(CB_UNLOCK1);
        lows.push_back(UNLOCK_ADDR2);
        vals.push_back(CB_UNLOCK2);
        case (kind)
            JK_PROGRAM:
            begin
                lows.push_back(UNLOCK_ADDR1);
                vals.push_back(CB_PROGRAM);
            end
            JK_RESET3:
            begin
                lows.push_back(11'($urandom));
                vals.push_back(CB_RESET);
            end
            default:
            begin
                lows.push_back(UNLOCK_ADDR1);
                vals.push_back(CB_ERASE);
                lows.push_back(UNLOCK_ADDR1);
                vals.push_back(CB_UNLOCK1);
                lows.push_back(UNLOCK_ADDR2);
                vals.push_back(CB_UNLOCK2);
                if (kind == JK_CHIP_ERASE)
                begin
                    lows.push_back(UNLOCK_ADDR1);
                    vals.push_back(CB_CHIP);
                end
            end
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            j = $urandom_range(0, lows.size() - 1);
            if ($urandom_range(0, 1) == 0)
                vals[j] = 8'($urandom);
            else
                lows[j] = 11'($urandom);
        end
        foreach (lows[i])
            offer(CMD_MEM_WRITE, {2'b00, 3'($urandom_range(0, 7)), lows[i]}, vals[i]);
        if (kind == JK_PROGRAM)
            offer(CMD_MEM_WRITE, rand_window(), 8'($urandom));
        else if (kind == JK_BLOCK_ERASE)
            offer(CMD_MEM_WRITE, rand_window(), CB_BLOCK);
        // reads after an erase pick up the status byte
        if (kind == JK_CHIP_ERASE || kind == JK_BLOCK_ERASE)
            repeat ($urandom_range(1, 3))
                offer(CMD_MEM_READ, rand_window(), 8'($urandom));
    endtask

    task automatic offer_random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            offer_jedec(JK_PROGRAM);
        else if (pick < 35)
            offer_jedec(JK_BLOCK_ERASE);
        else if (pick < 42)
            offer_jedec(JK_CHIP_ERASE);
        else if (pick < 47)
            offer_jedec(JK_RESET3);
        else if (pick < 52)
        begin
            // bypass, autoselect or read/reset in the first step
            case ($urandom_range(0, 2))
                0: offer(CMD_MEM_WRITE, rand_window(), CB_PROGRAM);
                1: offer(CMD_MEM_WRITE, rand_window(), CB_AUTOSEL);
                default: offer(CMD_MEM_WRITE, rand_window(), CB_RESET);
            endcase
            offer(CMD_MEM_WRITE, rand_window(), 8'($urandom));
        end
        else if (pick < 58)
            offer_paging();
        else if (pick < 62)
            offer_card();
        else if (pick < 66)
            offer(CMD_PORT_WRITE, 16'($urandom), 8'($urandom));
        else if (pick < 70)
            offer(CMD_PAGE_READ, 16'($urandom), 8'($urandom));
        else if (pick < 80)
            offer(CMD_MEM_READ, rand_window(), 8'($urandom));
        else
            // noise: any code; half of the addresses in the window, the rest anywhere
            offer(3'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) == 0) ? rand_window() : 16'($urandom),
                  8'($urandom));
    endtask

    // Sender: items change at the falling edge; a burst of idle cycles is
    // dropped in now and then while gaps are enabled.
    task automatic drive_stimulus();
        bus_item_t it;
        while (stim_q.size() != 0)
        begin
            if (sender_gaps && $urandom_range(0, 9) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            it = stim_q.pop_front();
            on_bus = it;
            req_ch.valid <= 1'b1;
            req_ch.command <= it.cmd;
            req_ch.address <= it.addr;
            req_ch.data <= it.data;
            @(posedge clk);
            while (req_ch.ready !== 1'b1)
                @(posedge clk);
            @(negedge clk);
        end
        req_ch.valid <= 1'b0;
    endtask

    // Block is idle once every expected item is back and a few more cycles
    // have passed; returns on a falling edge.
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_protect(input logic v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver: random stall bursts, plus one long hold requested by the
    // main flow so the output buffer fills and req.ready drops.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 9) == 0)
            begin
                rx_gap = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Main flow: reset, directed table, then four random phases that swap
    // the write protect bit. Phase 1 carries the long receiver hold; the
    // last phase runs without any idling.
    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = '0;
        req_ch.address = '0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 1'b0;
        on_bus = row(CMD_MEM_READ, '0, '0, 1'b0, '0);
        wprot = 1'b0;
        pg_ctl = PAGING_RESET;
        card_nib = 4'h0;
        seq_step = 3'd1;
        seq_pfx = PX_NONE;
        status_pend = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            stim_q.push_back(directed_row(i));
        drive_stimulus();

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            write_protect(ph % 2 == 0);
            if (ph == 3)
            begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
            // make sure command sequences can reach the sequencer
            offer(CMD_CARD_WRITE, 16'($urandom), {CARD_UNLOCK, 4'($urandom)});
            offer(CMD_PAGE_WRITE, 16'($urandom), {2'($urandom), 1'b1, 5'($urandom)} | 8'h40);
            while (stim_q.size() < ITEMS_PER_PHASE)
                offer_random_burst();
            if (ph == 1)
                hold_req++;
            drive_stimulus();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS banked_flash_command_interface_top");
        else
            $display("FAIL banked_flash_command_interface_top");
        $finish;
    end

endmodule

/* banked_flash_command_interface_top.f */
src/bfci_pkg.sv
src/bfci_if.sv
src/bfci_core.sv
src/bfci_outbuf.sv
src/banked_flash_command_interface_top.sv
bench/testbench.sv
